// ===== hdl/assert_macros.svh =====
// assertion helpers for the blink sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, ignored while in reset
`define LBPS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lbps assertion failed");

// next-cycle implication, ignored while in reset
`define LBPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lbps assertion failed");

`else

`define LBPS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define LBPS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/lbps_pkg.sv =====
`default_nettype none

package lbps_pkg;

    // default width of the millisecond counters
    localparam int unsigned TIME_BITS_DEF = 16;

    // width of the configured durations
    localparam int unsigned DUR_BITS = 16;
    localparam int unsigned REP_BITS = 8;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 16;

    // input word kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_SELECT = 2'd2;

    // pattern codes
    localparam logic [1:0] PAT_NORMAL = 2'd0;
    localparam logic [1:0] PAT_ERROR  = 2'd1;
    localparam logic [1:0] PAT_FAST   = 2'd2;
    localparam logic [1:0] PAT_CUSTOM = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CUSTOM_ON    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CUSTOM_OFF   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CUSTOM_PAUSE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CUSTOM_REP   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEALTH_EN    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHECK_PERIOD = 3'd5;

    // fixed pattern timing
    localparam logic [DUR_BITS-1:0] NORMAL_ON_MS    = 16'd1000;
    localparam logic [DUR_BITS-1:0] NORMAL_OFF_MS   = 16'd1000;
    localparam logic [DUR_BITS-1:0] ERROR_ON_MS     = 16'd50;
    localparam logic [DUR_BITS-1:0] ERROR_OFF_MS    = 16'd50;
    localparam logic [DUR_BITS-1:0] FAST_ON_MS      = 16'd250;
    localparam logic [DUR_BITS-1:0] FAST_OFF_MS     = 16'd250;
    localparam logic [DUR_BITS-1:0] FIXED_PAUSE_MS  = 16'd1000;

    // register reset values
    localparam logic [DUR_BITS-1:0] RST_CUSTOM_MS    = 16'd1000;
    localparam logic [REP_BITS-1:0] RST_CUSTOM_REP   = 8'd0;
    localparam logic [DUR_BITS-1:0] RST_CHECK_PERIOD = 16'd1000;

    // reported phase codes
    localparam logic [2:0] PHASE_INIT     = 3'd0;
    localparam logic [2:0] PHASE_ON       = 3'd1;
    localparam logic [2:0] PHASE_ON_WAIT  = 3'd2;
    localparam logic [2:0] PHASE_OFF_WAIT = 3'd3;
    localparam logic [2:0] PHASE_PAUSE    = 3'd4;

    // phase machine states
    typedef enum logic [4:0] {
        PH_INIT     = 5'b00001,
        PH_ON       = 5'b00010,
        PH_ON_WAIT  = 5'b00100,
        PH_OFF_WAIT = 5'b01000,
        PH_PAUSE    = 5'b10000
    } phase_t;

    // configuration registers
    typedef struct packed {
        logic [DUR_BITS-1:0] custom_on;
        logic [DUR_BITS-1:0] custom_off;
        logic [DUR_BITS-1:0] custom_pause;
        logic [REP_BITS-1:0] custom_repeats;
        logic                health_en;
        logic [DUR_BITS-1:0] check_period;
    } cfg_t;

    // timing of the pattern in use
    typedef struct packed {
        logic [DUR_BITS-1:0] on_ms;
        logic [DUR_BITS-1:0] off_ms;
        logic [DUR_BITS-1:0] pause_ms;
        logic [REP_BITS-1:0] repeats;
    } pat_t;

    // status reported with each result word
    typedef struct packed {
        logic       led_on;
        logic [2:0] phase;
        logic [1:0] pattern;
    } status_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_INIT:     code = PHASE_INIT;
            PH_ON:       code = PHASE_ON;
            PH_ON_WAIT:  code = PHASE_ON_WAIT;
            PH_OFF_WAIT: code = PHASE_OFF_WAIT;
            PH_PAUSE:    code = PHASE_PAUSE;
            default:     code = PHASE_INIT;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/led_blink_pattern_sequencer.sv =====
// channel   direction  ports                                          handshake
// s_        in         s_kind, s_pattern_choice, s_healthy            s_valid / s_ready
// m_        out        m_led_on, m_phase, m_pattern_in_use            m_valid / m_ready
// cfg_      in         cfg_idx, cfg_wdata                             cfg_we, no wait
//
// one word per clock while the result side is not stalled; the phase step
// loads the result register from the input register, so m_valid rises then
// aresetn is synchronous and active low; it clears the phase state, timers
// and the configuration registers to their defaults
// a stalled result holds the result register; the input register still takes
// a word while it is empty, or the result register is free or being drained
`default_nettype none

module led_blink_pattern_sequencer #(
    parameter int unsigned TIME_BITS = lbps_pkg::TIME_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output wire logic                                s_ready,
    input  wire logic [1:0]                          s_kind,
    input  wire logic [1:0]                          s_pattern_choice,
    input  wire logic                                s_healthy,
    output wire logic                                m_valid,
    input  wire logic                                m_ready,
    output wire logic                                m_led_on,
    output wire logic [2:0]                          m_phase,
    output wire logic [1:0]                          m_pattern_in_use,
    input  wire logic                                cfg_we,
    input  wire logic [lbps_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
    input  wire logic [lbps_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    lbps_pkg::cfg_t     cfg_reg;
    logic               in_valid_reg;
    logic [1:0]         in_kind_reg;
    logic [1:0]         in_choice_reg;
    logic               in_healthy_reg;
    logic               out_valid_reg;
    lbps_pkg::status_t  out_reg;
    lbps_pkg::status_t  status_next;
    logic               advance;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || !out_valid_reg || m_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.custom_on      <= lbps_pkg::RST_CUSTOM_MS;
            cfg_reg.custom_off     <= lbps_pkg::RST_CUSTOM_MS;
            cfg_reg.custom_pause   <= lbps_pkg::RST_CUSTOM_MS;
            cfg_reg.custom_repeats <= lbps_pkg::RST_CUSTOM_REP;
            cfg_reg.health_en      <= 1'b0;
            cfg_reg.check_period   <= lbps_pkg::RST_CHECK_PERIOD;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                lbps_pkg::REG_CUSTOM_ON:    cfg_reg.custom_on <= cfg_wdata;
                lbps_pkg::REG_CUSTOM_OFF:   cfg_reg.custom_off <= cfg_wdata;
                lbps_pkg::REG_CUSTOM_PAUSE: cfg_reg.custom_pause <= cfg_wdata;
                lbps_pkg::REG_CUSTOM_REP:   cfg_reg.custom_repeats <= cfg_wdata[7:0];
                lbps_pkg::REG_HEALTH_EN:    cfg_reg.health_en <= cfg_wdata[0];
                lbps_pkg::REG_CHECK_PERIOD: cfg_reg.check_period <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg    <= s_kind;
            in_choice_reg  <= s_pattern_choice;
            in_healthy_reg <= s_healthy;
        end
    end

    // phase machine and timers
    lbps_phase_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_phase_fsm (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .kind           (in_kind_reg),
        .pattern_choice (in_choice_reg),
        .healthy        (in_healthy_reg),
        .cfg            (cfg_reg),
        .status_next    (status_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= status_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_led_on         = out_reg.led_on;
    assign m_phase          = out_reg.phase;
    assign m_pattern_in_use = out_reg.pattern;

    // checks
`include "assert_macros.svh"

    `LBPS_ASSERT_NEXT(a_select_restarts, aclk, aresetn,
        advance && (in_kind_reg == lbps_pkg::KIND_SELECT),
        m_phase == lbps_pkg::PHASE_INIT)
    `LBPS_ASSERT_IMPL(a_on_wait_lit, aclk, aresetn,
        out_valid_reg && (out_reg.phase == lbps_pkg::PHASE_ON_WAIT),
        out_reg.led_on)
    `LBPS_ASSERT_IMPL(a_dark_phases, aclk, aresetn,
        out_valid_reg && ((out_reg.phase == lbps_pkg::PHASE_OFF_WAIT)
            || (out_reg.phase == lbps_pkg::PHASE_PAUSE)),
        !out_reg.led_on)
    `LBPS_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_ready)

endmodule

`default_nettype wire

// ===== hdl/lbps_pattern_lut.sv =====
`default_nettype none

module lbps_pattern_lut (
    input  wire logic [1:0]    pattern,
    input  lbps_pkg::cfg_t     cfg,
    output lbps_pkg::pat_t     pat
);

    // fixed patterns blink endlessly, custom takes the registers
    always_comb begin
        unique case (pattern)
            lbps_pkg::PAT_NORMAL: begin
                pat.on_ms    = lbps_pkg::NORMAL_ON_MS;
                pat.off_ms   = lbps_pkg::NORMAL_OFF_MS;
                pat.pause_ms = lbps_pkg::FIXED_PAUSE_MS;
                pat.repeats  = '0;
            end
            lbps_pkg::PAT_ERROR: begin
                pat.on_ms    = lbps_pkg::ERROR_ON_MS;
                pat.off_ms   = lbps_pkg::ERROR_OFF_MS;
                pat.pause_ms = lbps_pkg::FIXED_PAUSE_MS;
                pat.repeats  = '0;
            end
            lbps_pkg::PAT_FAST: begin
                pat.on_ms    = lbps_pkg::FAST_ON_MS;
                pat.off_ms   = lbps_pkg::FAST_OFF_MS;
                pat.pause_ms = lbps_pkg::FIXED_PAUSE_MS;
                pat.repeats  = '0;
            end
            lbps_pkg::PAT_CUSTOM: begin
                pat.on_ms    = cfg.custom_on;
                pat.off_ms   = cfg.custom_off;
                pat.pause_ms = cfg.custom_pause;
                pat.repeats  = cfg.custom_repeats;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/lbps_phase_fsm.sv =====
`default_nettype none

module lbps_phase_fsm #(
    parameter int unsigned TIME_BITS = lbps_pkg::TIME_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire logic [1:0]          kind,
    input  wire logic [1:0]          pattern_choice,
    input  wire logic                healthy,
    input  lbps_pkg::cfg_t           cfg,
    output lbps_pkg::status_t        status_next
);

    localparam int unsigned CMP_W =
        (TIME_BITS > lbps_pkg::DUR_BITS) ? TIME_BITS : lbps_pkg::DUR_BITS;

    lbps_pkg::phase_t                phase_reg, phase_next;
    logic                            led_reg, led_next;
    logic [TIME_BITS-1:0]            blink_timer_reg, blink_timer_next;
    logic [TIME_BITS-1:0]            check_timer_reg, check_timer_next;
    logic [lbps_pkg::REP_BITS-1:0]   blinks_left_reg, blinks_left_next;
    logic [lbps_pkg::REP_BITS-1:0]   blinks_dec;
    logic [1:0]                      pattern_reg, pattern_next;
    logic [1:0]                      pattern_eff;
    logic                            check_due;
    logic [lbps_pkg::DUR_BITS-1:0]   pause_need;
    logic [CMP_W-1:0]                blink_ext;
    lbps_pkg::pat_t                  pat;

    // health check swaps the pattern ahead of the phase step
    assign check_due = CMP_W'(check_timer_reg) >= CMP_W'(cfg.check_period);

    always_comb begin
        pattern_eff = pattern_reg;
        if (step && (kind == lbps_pkg::KIND_UPDATE) && check_due && cfg.health_en) begin
            pattern_eff = healthy ? lbps_pkg::PAT_NORMAL : lbps_pkg::PAT_ERROR;
        end
    end

    lbps_pattern_lut u_pattern_lut (
        .pattern (pattern_eff),
        .cfg     (cfg),
        .pat     (pat)
    );

    // timing compares for the phase step
    assign blink_ext  = CMP_W'(blink_timer_reg);
    assign pause_need = (pat.pause_ms > pat.off_ms) ? (pat.pause_ms - pat.off_ms) : '0;
    assign blinks_dec = blinks_left_reg - 1'b1;

    // next state for the accepted word
    always_comb begin
        phase_next       = phase_reg;
        led_next         = led_reg;
        blink_timer_next = blink_timer_reg;
        check_timer_next = check_timer_reg;
        blinks_left_next = blinks_left_reg;
        pattern_next     = pattern_reg;
        if (step) begin
            unique case (kind)
                lbps_pkg::KIND_TICK: begin
                    if (blink_timer_reg != '1) begin
                        blink_timer_next = blink_timer_reg + 1'b1;
                    end
                    if (check_timer_reg != '1) begin
                        check_timer_next = check_timer_reg + 1'b1;
                    end
                end
                lbps_pkg::KIND_UPDATE: begin
                    if (check_due) begin
                        check_timer_next = '0;
                    end
                    pattern_next = pattern_eff;
                    unique case (phase_reg)
                        lbps_pkg::PH_INIT: begin
                            blinks_left_next = (pat.repeats != '0) ? pat.repeats : 8'd1;
                            phase_next = lbps_pkg::PH_ON;
                        end
                        lbps_pkg::PH_ON: begin
                            led_next         = 1'b1;
                            blink_timer_next = '0;
                            phase_next       = lbps_pkg::PH_ON_WAIT;
                        end
                        lbps_pkg::PH_ON_WAIT: begin
                            if (blink_ext >= CMP_W'(pat.on_ms)) begin
                                led_next         = 1'b0;
                                blink_timer_next = '0;
                                phase_next       = lbps_pkg::PH_OFF_WAIT;
                            end
                        end
                        lbps_pkg::PH_OFF_WAIT: begin
                            if (blink_ext >= CMP_W'(pat.off_ms)) begin
                                blink_timer_next = '0;
                                if (pat.repeats == '0) begin
                                    phase_next = lbps_pkg::PH_ON;
                                end else begin
                                    blinks_left_next = blinks_dec;
                                    phase_next = (blinks_dec != '0) ?
                                        lbps_pkg::PH_ON : lbps_pkg::PH_PAUSE;
                                end
                            end
                        end
                        lbps_pkg::PH_PAUSE: begin
                            if (blink_ext >= CMP_W'(pause_need)) begin
                                blink_timer_next = '0;
                                phase_next       = lbps_pkg::PH_INIT;
                            end
                        end
                        default: begin
                            phase_next = lbps_pkg::PH_INIT;
                        end
                    endcase
                end
                lbps_pkg::KIND_SELECT: begin
                    pattern_next = pattern_choice;
                    phase_next   = lbps_pkg::PH_INIT;
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= lbps_pkg::PH_INIT;
            led_reg         <= 1'b0;
            blink_timer_reg <= '0;
            check_timer_reg <= '0;
            blinks_left_reg <= '0;
            pattern_reg     <= lbps_pkg::PAT_NORMAL;
        end else begin
            phase_reg       <= phase_next;
            led_reg         <= led_next;
            blink_timer_reg <= blink_timer_next;
            check_timer_reg <= check_timer_next;
            blinks_left_reg <= blinks_left_next;
            pattern_reg     <= pattern_next;
        end
    end

    // status after this word
    assign status_next.led_on  = led_next;
    assign status_next.phase   = lbps_pkg::phase_code(phase_next);
    assign status_next.pattern = pattern_next;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    typedef logic [lbps_pkg::DUR_BITS-1:0]      dur_t;
    typedef logic [lbps_pkg::REP_BITS-1:0]      rep_t;
    typedef logic [lbps_pkg::CFG_IDX_BITS-1:0]  cfg_idx_t;
    typedef logic [lbps_pkg::CFG_DATA_BITS-1:0] cfg_data_t;

    // codes the package leaves out
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam cfg_idx_t   REG_UNUSED  = 3'd7;

    localparam int unsigned    TW            = lbps_pkg::TIME_BITS_DEF;
    localparam logic [TW-1:0]  TIME_MAX      = '1;
    localparam int unsigned    LONG_TICKS    = 40;
    localparam int unsigned    STRETCH_WORDS = 90;
    localparam int unsigned    IDLE_PCT      = 34;

    // one row of the directed script: a register write or an input word
    typedef struct packed {
        bit                 is_write;
        cfg_idx_t           idx;
        cfg_data_t          data;
        logic [1:0]         kind;
        logic [1:0]         choice;
        logic               healthy;
        bit                 typed;
        lbps_pkg::status_t  want;
    } step_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    wire            s_ready;
    logic [1:0]     s_kind = lbps_pkg::KIND_TICK;
    logic [1:0]     s_pattern_choice = lbps_pkg::PAT_NORMAL;
    logic           s_healthy = 1'b0;
    wire            m_valid;
    logic           m_ready = 1'b0;
    wire            m_led_on;
    wire [2:0]      m_phase;
    wire [1:0]      m_pattern_in_use;
    logic           cfg_we = 1'b0;
    cfg_idx_t       cfg_idx = lbps_pkg::REG_CUSTOM_ON;
    cfg_data_t      cfg_wdata = '0;

    // blinker model state and its copy of the registers
    dur_t           cfg_on = lbps_pkg::RST_CUSTOM_MS;
    dur_t           cfg_off = lbps_pkg::RST_CUSTOM_MS;
    dur_t           cfg_pause = lbps_pkg::RST_CUSTOM_MS;
    rep_t           cfg_reps = lbps_pkg::RST_CUSTOM_REP;
    logic           cfg_health = 1'b0;
    dur_t           cfg_period = lbps_pkg::RST_CHECK_PERIOD;
    logic [2:0]     seq_phase = lbps_pkg::PHASE_INIT;
    logic           led = 1'b0;
    logic [TW-1:0]  blink_ms = '0;
    logic [TW-1:0]  check_ms = '0;
    rep_t           burst_left = '0;
    logic [1:0]     active_pat = lbps_pkg::PAT_NORMAL;

    lbps_pkg::status_t  pending_status[$];
    step_row_t          script[$];
    int unsigned        fail_count = 0;
    int unsigned        words_sent = 0;
    int unsigned        idle_pct = IDLE_PCT;

    led_blink_pattern_sequencer u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_pattern_choice   (s_pattern_choice),
        .s_healthy          (s_healthy),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_led_on           (m_led_on),
        .m_phase            (m_phase),
        .m_pattern_in_use   (m_pattern_in_use),
        .cfg_we             (cfg_we),
        .cfg_idx            (cfg_idx),
        .cfg_wdata          (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // timing of the pattern in use
    function automatic dur_t on_ms_now();
        unique case (active_pat)
            lbps_pkg::PAT_NORMAL: return lbps_pkg::NORMAL_ON_MS;
            lbps_pkg::PAT_ERROR:  return lbps_pkg::ERROR_ON_MS;
            lbps_pkg::PAT_FAST:   return lbps_pkg::FAST_ON_MS;
            default:              return cfg_on;
        endcase
    endfunction

    function automatic dur_t off_ms_now();
        unique case (active_pat)
            lbps_pkg::PAT_NORMAL: return lbps_pkg::NORMAL_OFF_MS;
            lbps_pkg::PAT_ERROR:  return lbps_pkg::ERROR_OFF_MS;
            lbps_pkg::PAT_FAST:   return lbps_pkg::FAST_OFF_MS;
            default:              return cfg_off;
        endcase
    endfunction

    function automatic rep_t repeats_now();
        return (active_pat == lbps_pkg::PAT_CUSTOM) ? cfg_reps : '0;
    endfunction

    // pause counts the off time too, so only the rest is waited
    function automatic dur_t pause_rest();
        dur_t total;
        total = (active_pat == lbps_pkg::PAT_CUSTOM) ? cfg_pause : lbps_pkg::FIXED_PAUSE_MS;
        return (total > off_ms_now()) ? total - off_ms_now() : '0;
    endfunction

    // advance the blinker model by one word, return the status it reports
    function automatic lbps_pkg::status_t blink_step(input logic [1:0] kind,
                                                     input logic [1:0] choice,
                                                     input logic healthy);
        lbps_pkg::status_t res;
        unique case (kind)
            lbps_pkg::KIND_TICK: begin
                if (blink_ms != TIME_MAX) blink_ms = blink_ms + 1'b1;
                if (check_ms != TIME_MAX) check_ms = check_ms + 1'b1;
            end
            lbps_pkg::KIND_UPDATE: begin
                // periodic health check ahead of the phase step
                if (check_ms >= cfg_period) begin
                    check_ms = '0;
                    if (cfg_health) begin
                        active_pat = healthy ? lbps_pkg::PAT_NORMAL : lbps_pkg::PAT_ERROR;
                    end
                end
                unique case (seq_phase)
                    lbps_pkg::PHASE_INIT: begin
                        burst_left = (repeats_now() != '0) ? repeats_now() : rep_t'(1);
                        seq_phase = lbps_pkg::PHASE_ON;
                    end
                    lbps_pkg::PHASE_ON: begin
                        led = 1'b1;
                        blink_ms = '0;
                        seq_phase = lbps_pkg::PHASE_ON_WAIT;
                    end
                    lbps_pkg::PHASE_ON_WAIT: begin
                        if (blink_ms >= on_ms_now()) begin
                            led = 1'b0;
                            blink_ms = '0;
                            seq_phase = lbps_pkg::PHASE_OFF_WAIT;
                        end
                    end
                    lbps_pkg::PHASE_OFF_WAIT: begin
                        if (blink_ms >= off_ms_now()) begin
                            blink_ms = '0;
                            if (repeats_now() == '0) begin
                                seq_phase = lbps_pkg::PHASE_ON;
                            end else begin
                                burst_left = burst_left - 1'b1;
                                seq_phase = (burst_left != '0) ?
                                    lbps_pkg::PHASE_ON : lbps_pkg::PHASE_PAUSE;
                            end
                        end
                    end
                    lbps_pkg::PHASE_PAUSE: begin
                        if (blink_ms >= pause_rest()) begin
                            blink_ms = '0;
                            seq_phase = lbps_pkg::PHASE_INIT;
                        end
                    end
                    default: seq_phase = lbps_pkg::PHASE_INIT;
                endcase
            end
            lbps_pkg::KIND_SELECT: begin
                active_pat = choice;
                seq_phase = lbps_pkg::PHASE_INIT;
            end
            default: ;
        endcase
        res.led_on = led;
        res.phase = seq_phase;
        res.pattern = active_pat;
        return res;
    endfunction

    // ticks still missing before the current wait phase can move on
    function automatic int unsigned ticks_needed();
        int unsigned target;
        int unsigned now_ms;
        now_ms = 32'(blink_ms);
        unique case (seq_phase)
            lbps_pkg::PHASE_ON_WAIT:  target = 32'(on_ms_now());
            lbps_pkg::PHASE_OFF_WAIT: target = 32'(off_ms_now());
            lbps_pkg::PHASE_PAUSE:    target = 32'(pause_rest());
            default:                  target = 32'd0;
        endcase
        return (target > now_ms) ? target - now_ms : 32'd0;
    endfunction

    function automatic void report_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    // result side: random stalls, compare against the oldest expectation
    always @(posedge aclk) m_ready <= ($urandom_range(0, 99) >= idle_pct);

    always @(posedge aclk) begin
        lbps_pkg::status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                report_fail($sformatf("unexpected result word: led %0d phase %0d pattern %0d",
                                      m_led_on, m_phase, m_pattern_in_use));
            end else begin
                want = pending_status.pop_front();
                if (m_led_on !== want.led_on || m_phase !== want.phase
                        || m_pattern_in_use !== want.pattern) begin
                    report_fail($sformatf({"status mismatch: expected led %0d phase %0d ",
                                           "pattern %0d, got led %0d phase %0d pattern %0d"},
                                          want.led_on, want.phase, want.pattern,
                                          m_led_on, m_phase, m_pattern_in_use));
                end
            end
        end
    end

    // input side: optional idle cycles, then hold the word until taken
    task automatic send_word(input logic [1:0] kind, input logic [1:0] choice,
                             input logic healthy, input bit typed,
                             input lbps_pkg::status_t typed_want);
        lbps_pkg::status_t predicted;
        cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_pattern_choice <= choice;
        s_healthy <= healthy;
        do @(posedge aclk); while (!s_ready);
        predicted = blink_step(kind, choice, healthy);
        pending_status.push_back(typed ? typed_want : predicted);
        if (kind != KIND_UNUSED) words_sent++;
    endtask

    // stop sending and wait until every expected word is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        unique case (idx)
            lbps_pkg::REG_CUSTOM_ON:    cfg_on = data;
            lbps_pkg::REG_CUSTOM_OFF:   cfg_off = data;
            lbps_pkg::REG_CUSTOM_PAUSE: cfg_pause = data;
            lbps_pkg::REG_CUSTOM_REP:   cfg_reps = data[lbps_pkg::REP_BITS-1:0];
            lbps_pkg::REG_HEALTH_EN:    cfg_health = data[0];
            lbps_pkg::REG_CHECK_PERIOD: cfg_period = data;
            default: ;
        endcase
    endtask

    function automatic step_row_t word_row(input logic [1:0] kind, input logic [1:0] choice,
                                           input logic healthy, input bit typed,
                                           input logic led_on, input logic [2:0] phase,
                                           input logic [1:0] pat);
        step_row_t r;
        r = '0;
        r.kind = kind;
        r.choice = choice;
        r.healthy = healthy;
        r.typed = typed;
        r.want.led_on = led_on;
        r.want.phase = phase;
        r.want.pattern = pat;
        return r;
    endfunction

    function automatic step_row_t reg_row(input cfg_idx_t idx, input cfg_data_t data);
        step_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic dur_t pick_ms();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return '1;
        if (roll < 9) return '0;
        return dur_t'($urandom_range(1, 16));
    endfunction

    // fresh register settings between random stretches
    task automatic random_settings();
        cfg_data_t data;
        int unsigned roll;
        drain_results();
        write_reg(lbps_pkg::REG_CUSTOM_ON, pick_ms());
        write_reg(lbps_pkg::REG_CUSTOM_OFF, pick_ms());
        write_reg(lbps_pkg::REG_CUSTOM_PAUSE, pick_ms());
        // upper data bits are junk, only the low byte counts
        data = cfg_data_t'($urandom_range(0, 65535));
        roll = $urandom_range(0, 99);
        if (roll < 30) data[lbps_pkg::REP_BITS-1:0] = '0;
        else if (roll < 36) data[lbps_pkg::REP_BITS-1:0] = '1;
        else data[lbps_pkg::REP_BITS-1:0] = rep_t'($urandom_range(1, 6));
        write_reg(lbps_pkg::REG_CUSTOM_REP, data);
        data = cfg_data_t'($urandom_range(0, 65535));
        data[0] = ($urandom_range(0, 3) == 0);
        write_reg(lbps_pkg::REG_HEALTH_EN, data);
        roll = $urandom_range(0, 99);
        if (roll < 10) data = '0;
        else if (roll < 15) data = '1;
        else data = cfg_data_t'($urandom_range(5, 60));
        write_reg(lbps_pkg::REG_CHECK_PERIOD, data);
        if ($urandom_range(0, 9) == 0) begin
            write_reg(REG_UNUSED, cfg_data_t'($urandom_range(0, 65535)));
        end
    endtask

    // a run of ticks, sometimes sized to let the current phase move on, then a step
    task automatic random_burst();
        int unsigned roll, run, need;
        logic [1:0] choice;
        need = ticks_needed();
        roll = $urandom_range(0, 99);
        if (roll < 55) run = $urandom_range(0, 5);
        else if (roll < 90 && need <= 80) run = need + $urandom_range(0, 2);
        else run = $urandom_range(0, 30);
        repeat (run) begin
            send_word(lbps_pkg::KIND_TICK, 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
        end
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
            send_word(lbps_pkg::KIND_UPDATE, 2'($urandom_range(0, 3)),
                      ($urandom_range(0, 99) < 35), 1'b0, '0);
        end else if (roll < 94) begin
            choice = $urandom_range(0, 1) ? lbps_pkg::PAT_CUSTOM : 2'($urandom_range(0, 3));
            send_word(lbps_pkg::KIND_SELECT, choice, 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
            send_word(KIND_UNUSED, 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    initial begin
        int unsigned stretch_end;

        // directed script, defaults after reset first
        script.push_back(word_row(lbps_pkg::KIND_TICK, lbps_pkg::PAT_CUSTOM, 1'b1, 1'b1,
                                  1'b0, lbps_pkg::PHASE_INIT, lbps_pkg::PAT_NORMAL));
        script.push_back(word_row(KIND_UNUSED, lbps_pkg::PAT_CUSTOM, 1'b1, 1'b1,
                                  1'b0, lbps_pkg::PHASE_INIT, lbps_pkg::PAT_NORMAL));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b0, lbps_pkg::PHASE_ON, lbps_pkg::PAT_NORMAL));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b1, lbps_pkg::PHASE_ON_WAIT, lbps_pkg::PAT_NORMAL));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b1, 1'b1,
                                  1'b1, lbps_pkg::PHASE_ON_WAIT, lbps_pkg::PAT_NORMAL));
        script.push_back(word_row(lbps_pkg::KIND_SELECT, lbps_pkg::PAT_ERROR, 1'b0, 1'b1,
                                  1'b1, lbps_pkg::PHASE_INIT, lbps_pkg::PAT_ERROR));
        script.push_back(word_row(lbps_pkg::KIND_SELECT, lbps_pkg::PAT_FAST, 1'b0, 1'b1,
                                  1'b1, lbps_pkg::PHASE_INIT, lbps_pkg::PAT_FAST));
        script.push_back(word_row(lbps_pkg::KIND_SELECT, lbps_pkg::PAT_NORMAL, 1'b1, 1'b1,
                                  1'b1, lbps_pkg::PHASE_INIT, lbps_pkg::PAT_NORMAL));
        // zero durations, full burst count, masked register data
        script.push_back(reg_row(lbps_pkg::REG_CUSTOM_ON, 16'h0000));
        script.push_back(reg_row(lbps_pkg::REG_CUSTOM_OFF, 16'h0000));
        script.push_back(reg_row(lbps_pkg::REG_CUSTOM_PAUSE, 16'h0000));
        script.push_back(reg_row(lbps_pkg::REG_CUSTOM_REP, 16'hFFFF));
        script.push_back(reg_row(lbps_pkg::REG_HEALTH_EN, 16'hFFFE));
        script.push_back(reg_row(lbps_pkg::REG_CHECK_PERIOD, 16'hFFFF));
        script.push_back(reg_row(REG_UNUSED, 16'hFFFF));
        script.push_back(word_row(lbps_pkg::KIND_SELECT, lbps_pkg::PAT_CUSTOM, 1'b0, 1'b1,
                                  1'b1, lbps_pkg::PHASE_INIT, lbps_pkg::PAT_CUSTOM));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b1, lbps_pkg::PHASE_ON, lbps_pkg::PAT_CUSTOM));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b1, lbps_pkg::PHASE_ON_WAIT, lbps_pkg::PAT_CUSTOM));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b0, lbps_pkg::PHASE_OFF_WAIT, lbps_pkg::PAT_CUSTOM));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b0, lbps_pkg::PHASE_ON, lbps_pkg::PAT_CUSTOM));
        // burst of one rewritten mid-sequence, pause no longer than off time
        script.push_back(reg_row(lbps_pkg::REG_CUSTOM_REP, 16'h0001));
        script.push_back(word_row(lbps_pkg::KIND_SELECT, lbps_pkg::PAT_CUSTOM, 1'b0, 1'b1,
                                  1'b0, lbps_pkg::PHASE_INIT, lbps_pkg::PAT_CUSTOM));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b0, lbps_pkg::PHASE_ON, lbps_pkg::PAT_CUSTOM));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b1, lbps_pkg::PHASE_ON_WAIT, lbps_pkg::PAT_CUSTOM));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b0, lbps_pkg::PHASE_OFF_WAIT, lbps_pkg::PAT_CUSTOM));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b0, lbps_pkg::PHASE_PAUSE, lbps_pkg::PAT_CUSTOM));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b0, lbps_pkg::PHASE_INIT, lbps_pkg::PAT_CUSTOM));
        // health check due on every update
        script.push_back(reg_row(lbps_pkg::REG_HEALTH_EN, 16'h0001));
        script.push_back(reg_row(lbps_pkg::REG_CHECK_PERIOD, 16'h0000));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b0, lbps_pkg::PHASE_ON, lbps_pkg::PAT_ERROR));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b1, 1'b1,
                                  1'b1, lbps_pkg::PHASE_ON_WAIT, lbps_pkg::PAT_NORMAL));
        script.push_back(word_row(lbps_pkg::KIND_TICK, lbps_pkg::PAT_NORMAL, 1'b0, 1'b0,
                                  1'b0, lbps_pkg::PHASE_INIT, lbps_pkg::PAT_NORMAL));
        // check due but disabled keeps the pattern
        script.push_back(reg_row(lbps_pkg::REG_HEALTH_EN, 16'h0000));
        script.push_back(word_row(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b1,
                                  1'b1, lbps_pkg::PHASE_ON_WAIT, lbps_pkg::PAT_NORMAL));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_write) begin
                if (i == 0 || !script[i-1].is_write) drain_results();
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_word(script[i].kind, script[i].choice, script[i].healthy,
                          script[i].typed, script[i].want);
            end
        end

        // random stretches, one of them with no idling on either side
        for (int k = 0; k < 7; k++) begin
            random_settings();
            idle_pct = (k == 3) ? 32'd0 : IDLE_PCT;
            stretch_end = words_sent + STRETCH_WORDS;
            while (words_sent < stretch_end) random_burst();
        end
        idle_pct = IDLE_PCT;

        // a long on time outlasts a run of ticks
        drain_results();
        write_reg(lbps_pkg::REG_CUSTOM_ON, 16'hFFFF);
        write_reg(lbps_pkg::REG_CUSTOM_OFF, 16'h0000);
        write_reg(lbps_pkg::REG_CUSTOM_REP, 16'h0000);
        write_reg(lbps_pkg::REG_HEALTH_EN, 16'h0000);
        write_reg(lbps_pkg::REG_CHECK_PERIOD, 16'hFFFF);
        send_word(lbps_pkg::KIND_SELECT, lbps_pkg::PAT_CUSTOM, 1'b1, 1'b0, '0);
        send_word(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b1, 1'b0, '0);
        send_word(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b1, 1'b0, '0);
        repeat (LONG_TICKS) begin
            send_word(lbps_pkg::KIND_TICK, 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
        end
        repeat (3) send_word(lbps_pkg::KIND_UPDATE, lbps_pkg::PAT_NORMAL, 1'b0, 1'b0, '0);

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
